[design/divsu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the signed/unsigned pipelined divider.
// No dependencies; every other file in this folder imports this package.
package divsu_pkg;

	// Width of every payload port.
	localparam int FIELD_W = 64;

	// Default operand width carried through the cell array.
	localparam int DATA_W_DEF = 64;

	// Operation codes.
	localparam logic OP_UNSIGNED = 1'b0;
	localparam logic OP_SIGNED   = 1'b1;

	// Control that travels beside the data through every stage.
	typedef struct packed {
		logic valid;
		logic neg_q;
		logic neg_r;
		logic den_zero;
	} divsu_ctl_t;

endpackage

[design/divsu_prep.sv]
`timescale 1ns / 1ps
// Entry stage: trims the operands to the datapath width and takes magnitudes.
// Depends on divsu_pkg.
module divsu_prep #(
	parameter int DATA_WIDTH = divsu_pkg::DATA_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic                           operation,
	input  logic [divsu_pkg::FIELD_W-1:0]  dividend,
	input  logic [divsu_pkg::FIELD_W-1:0]  divisor,
	output logic [DATA_WIDTH-1:0]          num,
	output logic [DATA_WIDTH-1:0]          den,
	output divsu_pkg::divsu_ctl_t          ctl
);
	import divsu_pkg::*;

	logic [DATA_WIDTH-1:0] n;
	logic [DATA_WIDTH-1:0] d;
	logic                  n_neg;
	logic                  d_neg;
	logic [DATA_WIDTH-1:0] un;
	logic [DATA_WIDTH-1:0] ud;
	logic [DATA_WIDTH-1:0] num_s1;
	logic [DATA_WIDTH-1:0] den_s1;
	logic                  valid_s1;
	logic                  neg_q_s1;
	logic                  neg_r_s1;
	logic                  den_zero_s1;

	// Take the low bits and the signs of both operands
	assign n     = dividend[DATA_WIDTH-1:0];
	assign d     = divisor[DATA_WIDTH-1:0];
	assign n_neg = (operation == OP_SIGNED) && n[DATA_WIDTH-1];
	assign d_neg = (operation == OP_SIGNED) && d[DATA_WIDTH-1];
	assign un    = n_neg ? ({DATA_WIDTH{1'b0}} - n) : n;
	assign ud    = d_neg ? ({DATA_WIDTH{1'b0}} - d) : d;

	// Advance the transfer valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load;
		end
	end

	// Hold magnitudes and result sign flags
	always_ff @(posedge clk) begin
		num_s1      <= un;
		den_s1      <= ud;
		neg_q_s1    <= n_neg ^ d_neg;
		neg_r_s1    <= n_neg;
		den_zero_s1 <= (d == {DATA_WIDTH{1'b0}});
	end

	assign num = num_s1;
	assign den = den_s1;
	assign ctl = '{valid: valid_s1, neg_q: neg_q_s1, neg_r: neg_r_s1,
		den_zero: den_zero_s1};

endmodule

[design/divsu_cell.sv]
`timescale 1ns / 1ps
// One restoring division step: shift in a dividend bit, trial subtract, keep or restore.
// Depends on divsu_pkg.
module divsu_cell #(
	parameter int DATA_WIDTH = divsu_pkg::DATA_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  divsu_pkg::divsu_ctl_t ctl_in,
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] num_in,
	input  logic [DATA_WIDTH-1:0] den_in,
	output divsu_pkg::divsu_ctl_t ctl_out,
	output logic [DATA_WIDTH-1:0] rem_out,
	output logic [DATA_WIDTH-1:0] num_out,
	output logic [DATA_WIDTH-1:0] den_out
);
	import divsu_pkg::*;

	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  fits;
	logic [DATA_WIDTH-1:0] rem_s1;
	logic [DATA_WIDTH-1:0] num_s1;
	logic [DATA_WIDTH-1:0] den_s1;
	logic                  valid_s1;
	logic                  neg_q_s1;
	logic                  neg_r_s1;
	logic                  den_zero_s1;

	// Shift the top dividend bit into the partial remainder and compare
	assign trial = {rem_in, num_in[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, den_in};
	assign fits  = !diff[DATA_WIDTH];

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl_in.valid;
		end
	end

	// Keep the difference when the divisor fits; quotient bit enters at the bottom
	always_ff @(posedge clk) begin
		rem_s1      <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
		num_s1      <= {num_in[DATA_WIDTH-2:0], fits};
		den_s1      <= den_in;
		neg_q_s1    <= ctl_in.neg_q;
		neg_r_s1    <= ctl_in.neg_r;
		den_zero_s1 <= ctl_in.den_zero;
	end

	assign ctl_out = '{valid: valid_s1, neg_q: neg_q_s1, neg_r: neg_r_s1,
		den_zero: den_zero_s1};
	assign rem_out = rem_s1;
	assign num_out = num_s1;
	assign den_out = den_s1;

endmodule

[design/divsu_post.sv]
`timescale 1ns / 1ps
// Exit stage: applies result signs, forces zero results on a zero divisor, drives outputs.
// Depends on divsu_pkg.
module divsu_post #(
	parameter int DATA_WIDTH = divsu_pkg::DATA_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  divsu_pkg::divsu_ctl_t         ctl_in,
	input  logic [DATA_WIDTH-1:0]         quo_in,
	input  logic [DATA_WIDTH-1:0]         rem_in,
	output logic                          done,
	output logic [divsu_pkg::FIELD_W-1:0] quotient,
	output logic [divsu_pkg::FIELD_W-1:0] remainder
);
	import divsu_pkg::*;

	logic [DATA_WIDTH-1:0] q_fix;
	logic [DATA_WIDTH-1:0] r_fix;
	logic [DATA_WIDTH-1:0] quo_s1;
	logic [DATA_WIDTH-1:0] rem_s1;
	logic                  done_s1;

	// Negate magnitudes as the operand signs require; drop results on a zero divisor
	always_comb begin
		q_fix = ctl_in.neg_q ? ({DATA_WIDTH{1'b0}} - quo_in) : quo_in;
		r_fix = ctl_in.neg_r ? ({DATA_WIDTH{1'b0}} - rem_in) : rem_in;
		if (ctl_in.den_zero) begin
			q_fix = {DATA_WIDTH{1'b0}};
			r_fix = {DATA_WIDTH{1'b0}};
		end
	end

	// Strobe the finished transfer for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= ctl_in.valid;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		quo_s1 <= q_fix;
		rem_s1 <= r_fix;
	end

	assign done      = done_s1;
	assign quotient  = FIELD_W'(quo_s1);
	assign remainder = FIELD_W'(rem_s1);

endmodule

[design/divider_64bit_signed_unsigned_unit.sv]
`timescale 1ns / 1ps
// Top level of the pipelined signed/unsigned restoring divider.
// Depends on divsu_pkg, divsu_prep, divsu_cell and divsu_post.
//
//   channel  | handshake       | payload
//   ---------+-----------------+-----------------------------------
//   command  | start, busy     | operation, dividend, divisor
//   result   | done (strobe)   | quotient, remainder
//
// One transfer is accepted every cycle; busy stays low.
// The pipeline is an entry stage, one cell per quotient
// bit in the cell chain, and an exit stage that drives the outputs.
// Reset clears only the valid flags of the chain; no state outlives a transfer.
// The receiver cannot stall: each result stands for one cycle with done high.
module divider_64bit_signed_unsigned_unit #(
	parameter int DATA_WIDTH = divsu_pkg::DATA_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [divsu_pkg::FIELD_W-1:0] dividend,
	input  logic [divsu_pkg::FIELD_W-1:0] divisor,
	output logic                          done,
	output logic [divsu_pkg::FIELD_W-1:0] quotient,
	output logic [divsu_pkg::FIELD_W-1:0] remainder
);
	import divsu_pkg::*;

	divsu_ctl_t            ctl_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] num_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] den_c [0:DATA_WIDTH];
	logic                  load;

	// Accept a command whenever start is high
	assign busy = 1'b0;
	assign load = start && !busy;

	// Take magnitudes and sign flags
	divsu_prep #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.operation(operation),
		.dividend (dividend),
		.divisor  (divisor),
		.num      (num_c[0]),
		.den      (den_c[0]),
		.ctl      (ctl_c[0])
	);

	// Partial remainder starts at zero
	assign rem_c[0] = {DATA_WIDTH{1'b0}};

	// Chain of division cells, one quotient bit each
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		divsu_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_c[i]),
			.rem_in (rem_c[i]),
			.num_in (num_c[i]),
			.den_in (den_c[i]),
			.ctl_out(ctl_c[i+1]),
			.rem_out(rem_c[i+1]),
			.num_out(num_c[i+1]),
			.den_out(den_c[i+1])
		);
	end

	// Fix signs and drive the result strobe
	divsu_post #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_c[DATA_WIDTH]),
		.quo_in   (num_c[DATA_WIDTH]),
		.rem_in   (rem_c[DATA_WIDTH]),
		.done     (done),
		.quotient (quotient),
		.remainder(remainder)
	);

endmodule
